// ----- sv/i2cmw_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmw_pkg
// shared types and constants of the i2c master write engine
// ----------------------------------------------------------------------------
package i2cmw_pkg;

    // width of the saturating tick counter
    localparam int TICK_BITS = 8;
    localparam logic [TICK_BITS-1:0] CNT_MAX = {TICK_BITS{1'b1}};

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_HALF_PERIOD   = 2'd1;
    localparam logic [1:0] CFG_START_HOLD    = 2'd2;

    // configuration reset values
    localparam logic [7:0] RST_SLAVE_ADDRESS = 8'he0;
    localparam logic [7:0] RST_HALF_PERIOD   = 8'd2;
    localparam logic [7:0] RST_START_HOLD    = 8'd4;

    // sequencer phases, one-hot
    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_HOLD      = 12'b0000_0000_0010,
        PH_START     = 12'b0000_0000_0100,
        PH_BIT_LO    = 12'b0000_0000_1000,
        PH_BIT_HI    = 12'b0000_0001_0000,
        PH_ACK_LO    = 12'b0000_0010_0000,
        PH_ACK_HI    = 12'b0000_0100_0000,
        PH_WAIT_DATA = 12'b0000_1000_0000,
        PH_STOP_LO   = 12'b0001_0000_0000,
        PH_STOP_HI   = 12'b0010_0000_0000,
        PH_STOP_LO_N = 12'b0100_0000_0000,
        PH_STOP_HI_N = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] half_period;
        logic [7:0] start_hold;
    } cfg_t;

    typedef struct packed {
        logic       tick;
        logic       begin_req;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last_byte;
        logic       sda_sense;
    } in_item_t;

    typedef struct packed {
        logic scl_level;
        logic sda_out;
        logic sda_drive;
        logic byte_taken;
        logic busy_res;
        logic done_res;
        logic nack;
    } res_item_t;

endpackage

// ----- sv/i2cmw_cfg.sv -----
// ----------------------------------------------------------------------------
// i2cmw_cfg
// configuration register file, written through a valid/ready channel
// ----------------------------------------------------------------------------
module i2cmw_cfg
    import i2cmw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       cfg_ready,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address <= RST_SLAVE_ADDRESS;
            cfg_reg.half_period   <= RST_HALF_PERIOD;
            cfg_reg.start_hold    <= RST_START_HOLD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_data;
                CFG_HALF_PERIOD:   cfg_reg.half_period   <= cfg_data;
                CFG_START_HOLD:    cfg_reg.start_hold    <= cfg_data;
                default:           ; // unused index, write dropped
            endcase
        end
    end

endmodule

// ----- sv/i2cmw_core.sv -----
// ----------------------------------------------------------------------------
// i2cmw_core
// bit sequencer: phase, counters, shifter and line levels, one item per step
// ----------------------------------------------------------------------------
module i2cmw_core
    import i2cmw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output res_item_t res
);

    localparam int CMP_W = ((TICK_BITS > 8) ? TICK_BITS : 8) + 1;

    phase_t               phase_reg,      phase_next;
    logic [3:0]           bit_count_reg,  bit_count_next;
    logic [TICK_BITS-1:0] tick_count_reg, tick_count_next;
    logic [7:0]           shift_reg,      shift_next;
    logic                 final_reg,      final_next;
    logic                 scl_reg,        scl_next;
    logic                 sda_reg,        sda_next;
    logic                 drv_reg,        drv_next;

    logic [7:0]           limit;
    logic [CMP_W-1:0]     cnt_inc;
    logic                 wait_hit;
    logic [TICK_BITS-1:0] wait_cnt;
    logic [3:0]           bit_inc;
    logic [7:0]           shifted;
    logic                 taken;
    logic                 done;
    logic                 nack;

    // shared phase timer: limit of 0 behaves like 1, saturation also ends it
    always_comb
    begin
        limit    = (phase_reg == PH_HOLD) ? cfg.start_hold : cfg.half_period;
        cnt_inc  = CMP_W'(tick_count_reg) + CMP_W'(1);
        wait_hit = item.tick && ((cnt_inc >= CMP_W'(limit)) || (tick_count_reg == CNT_MAX));
        if (wait_hit)
            wait_cnt = '0;
        else if (item.tick)
            wait_cnt = tick_count_reg + TICK_BITS'(1);
        else
            wait_cnt = tick_count_reg;
    end

    assign bit_inc = bit_count_reg + 4'd1;
    assign shifted = {shift_reg[6:0], 1'b0};

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        shift_next      = shift_reg;
        final_next      = final_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drv_next        = drv_reg;
        taken           = 1'b0;
        done            = 1'b0;
        nack            = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                scl_next = 1'b1;
                sda_next = 1'b1;
                drv_next = 1'b1;
                if (item.begin_req)
                begin
                    phase_next      = PH_HOLD;
                    tick_count_next = '0;
                    bit_count_next  = '0;
                    final_next      = 1'b0;
                end
            end
            PH_HOLD:
            begin
                tick_count_next = wait_cnt;
                if (wait_hit)
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                    phase_next = PH_START;
                end
            end
            PH_START:
            begin
                tick_count_next = wait_cnt;
                if (wait_hit)
                begin
                    shift_next     = cfg.slave_address;
                    bit_count_next = '0;
                    scl_next       = 1'b0;
                    sda_next       = cfg.slave_address[7];
                    drv_next       = 1'b1;
                    phase_next     = PH_BIT_LO;
                end
            end
            PH_BIT_LO:
            begin
                tick_count_next = wait_cnt;
                if (wait_hit)
                begin
                    scl_next   = 1'b1;
                    sda_next   = shift_reg[7];
                    drv_next   = 1'b1;
                    phase_next = PH_BIT_HI;
                end
            end
            PH_BIT_HI:
            begin
                tick_count_next = wait_cnt;
                if (wait_hit)
                begin
                    shift_next     = shifted;
                    bit_count_next = bit_inc;
                    scl_next       = 1'b0;
                    if (bit_inc[2:0] == 3'd0)
                    begin
                        // byte complete, release sda for the acknowledge
                        sda_next   = 1'b1;
                        drv_next   = 1'b0;
                        phase_next = PH_ACK_LO;
                    end
                    else
                    begin
                        sda_next   = shifted[7];
                        drv_next   = 1'b1;
                        phase_next = PH_BIT_LO;
                    end
                end
            end
            PH_ACK_LO:
            begin
                tick_count_next = wait_cnt;
                if (wait_hit)
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b0;
                    phase_next = PH_ACK_HI;
                end
            end
            PH_ACK_HI:
            begin
                tick_count_next = wait_cnt;
                if (wait_hit)
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                    drv_next = 1'b1;
                    if (item.sda_sense)
                        phase_next = PH_STOP_LO_N;
                    else if ((bit_count_reg == 4'd8) || !final_reg)
                        phase_next = PH_WAIT_DATA;
                    else
                        phase_next = PH_STOP_LO;
                end
            end
            PH_WAIT_DATA:
            begin
                if (item.data_valid)
                begin
                    taken           = 1'b1;
                    shift_next      = item.data_byte;
                    final_next      = item.last_byte;
                    bit_count_next  = 4'd8;
                    tick_count_next = '0;
                    scl_next        = 1'b0;
                    sda_next        = item.data_byte[7];
                    drv_next        = 1'b1;
                    phase_next      = PH_BIT_LO;
                end
            end
            PH_STOP_LO, PH_STOP_LO_N:
            begin
                tick_count_next = wait_cnt;
                if (wait_hit)
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    drv_next   = 1'b1;
                    phase_next = (phase_reg == PH_STOP_LO) ? PH_STOP_HI : PH_STOP_HI_N;
                end
            end
            PH_STOP_HI, PH_STOP_HI_N:
            begin
                tick_count_next = wait_cnt;
                if (wait_hit)
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    drv_next   = 1'b1;
                    done       = 1'b1;
                    nack       = (phase_reg == PH_STOP_HI_N);
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next      = PH_IDLE;
                tick_count_next = '0;
                bit_count_next  = '0;
                scl_next        = 1'b1;
                sda_next        = 1'b1;
                drv_next        = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        res.scl_level  = scl_next;
        res.sda_out    = sda_next;
        res.sda_drive  = drv_next;
        res.byte_taken = taken;
        res.busy_res   = (phase_next != PH_IDLE);
        res.done_res   = done;
        res.nack       = nack;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            tick_count_reg <= '0;
            shift_reg      <= '0;
            final_reg      <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drv_reg        <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            tick_count_reg <= tick_count_next;
            shift_reg      <= shift_next;
            final_reg      <= final_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            drv_reg        <= drv_next;
        end
    end

endmodule

// ----- sv/i2c_master_write_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_write_engine
// i2c master write sequencer with valid/stall item channels
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one item per clock unless
//   in_stall is high: a tick, a begin request, the next data byte with its
//   valid and last flags, and the sensed sda level. every accepted item yields
//   exactly one result item on the output channel (out_valid / out_stall) with
//   the scl and sda line levels, the sda drive enable, and the byte_taken,
//   busy, done, nack flags. two register stages: an item lands in the input
//   register at the edge that accepts it, is stepped through the sequencer
//   logic and lands in the result register when the result slot is free
//   throughput: one item per cycle when not stalled, the sequencer state is
//   one phase register plus counters updated in the same cycle an item moves on
//   stall: when out_stall holds a pending result, the input register keeps
//   its item and in_stall rises in the same cycle; nothing is lost
//   reset: rst_n clears both stage valid flags, puts the sequencer in idle
//   with both lines high and sda driven, and loads the configuration defaults
//   configuration: cfg_ready is always high; write only while idle
// ----------------------------------------------------------------------------
module i2c_master_write_engine
    import i2cmw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    // input item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       tick,
    input  logic       begin_req,
    input  logic [7:0] data_byte,
    input  logic       data_valid,
    input  logic       last_byte,
    input  logic       sda_sense,

    // result item channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_out,
    output logic       sda_drive,
    output logic       byte_taken,
    output logic       busy_res,
    output logic       done_res,
    output logic       nack
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    res_item_t res_comb;
    res_item_t res_reg;
    logic      out_valid_reg;
    logic      out_free;
    logic      step;

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // item in the input register moves through the sequencer
    assign step     = in_valid_reg && out_free;
    // input register can take a new item when empty or draining
    assign in_stall = in_valid_reg && !out_free;

    i2cmw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    i2cmw_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res_comb)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    // input stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg.tick       <= tick;
            in_item_reg.begin_req  <= begin_req;
            in_item_reg.data_byte  <= data_byte;
            in_item_reg.data_valid <= data_valid;
            in_item_reg.last_byte  <= last_byte;
            in_item_reg.sda_sense  <= sda_sense;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_comb;
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = res_reg.scl_level;
    assign sda_out    = res_reg.sda_out;
    assign sda_drive  = res_reg.sda_drive;
    assign byte_taken = res_reg.byte_taken;
    assign busy_res   = res_reg.busy_res;
    assign done_res   = res_reg.done_res;
    assign nack       = res_reg.nack;

endmodule
